@@ hdl/dsa_pkg.sv @@
// Shared types and constants of the table-driven string acceptor.
package dsa_pkg;

   // Fixed field widths of the request, response and register port.
   localparam int REQ_TYPE_W   = 3;
   localparam int STATE_W      = 6;
   localparam int SYMBOL_W     = 8;
   localparam int STATUS_W     = 3;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 6;

   // Layout of one transition table entry: exists flag above the target state.
   localparam int TRANS_W      = STATE_W + 1;
   localparam int TRANS_EXISTS = STATE_W;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_LOAD_TRANS  = 3'd0,
      REQ_LOAD_ACCEPT = 3'd1,
      REQ_LOAD_ALPHA  = 3'd2,
      REQ_START       = 3'd3,
      REQ_SYMBOL      = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_RUNNING   = 3'd0,
      STS_ACCEPTED  = 3'd1,
      STS_REJECTED  = 3'd2,
      STS_BAD_SYM   = 3'd3,
      STS_NO_TRANS  = 3'd4,
      STS_NO_INIT   = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_STATE   = 1'd0,
      CSR_INITIAL_DEFINED = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_STEP,
      FSM_FLAG,
      FSM_EMIT
   } fsm_type;

endpackage

@@ hdl/dsa_req_if.sv @@
// Request channel of the string acceptor: loads, string starts and symbols.
interface dsa_req_if;
   import dsa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [STATE_W-1:0]    state_index;
   logic [SYMBOL_W-1:0]   symbol;
   logic [STATE_W-1:0]    next_state;
   logic                  flag_value;
   logic                  last;

   modport source (
      output valid, req_type, state_index, symbol, next_state, flag_value, last,
      input  ready
   );

   modport sink (
      input  valid, req_type, state_index, symbol, next_state, flag_value, last,
      output ready
   );

endinterface

@@ hdl/dsa_rsp_if.sv @@
// Response channel of the string acceptor: one trace entry or verdict per beat.
interface dsa_rsp_if;
   import dsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATE_W-1:0]  current_state;
   logic [STATUS_W-1:0] status;
   logic                done_res;

   modport source (
      output valid, current_state, status, done_res,
      input  ready
   );

   modport sink (
      input  valid, current_state, status, done_res,
      output ready
   );

endinterface

@@ hdl/dsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module dsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/dfa_string_acceptor_core.sv @@
// Table-driven deterministic automaton: loads its tables and runs strings through them.
//
// Usage: the request channel carries load beats (transition, accepting flag,
// alphabet bit), start beats and symbol beats. Each start or symbol beat gives
// exactly one response beat with the state reached and a status; the beat
// marked last carries the verdict. Load beats give no response.
// The register port sets the initial state and whether one exists; write it
// only while no string item is in flight.
//
// Timing: loads are taken in the idle state, so they stream back to back. A
// start beat passes the emit state, after the flag state if it is the last
// of its string. A symbol beat passes the step state, then the flag state if
// last, then the emit state. The symbol path is one registered read of the
// transition table and the alphabet, then one registered read of the accepting
// flag at the new state for the verdict. The response sits in an output register.
//
// Reset: after reset the block sweeps all three tables to their cleared state,
// over NUM_STATES * 2**SYMBOL_BITS addresses (16384 at the defaults), ready low.
// A stalled response holds in the output register while the next request is
// taken; only a second finished result waits for the first to drain.
module dfa_string_acceptor_core #(
   parameter int NUM_STATES  = 64,
   parameter int SYMBOL_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   dsa_req_if.sink                     req_if,
   dsa_rsp_if.source                   rsp_if,
   input  logic                        csr_wr_en,
   input  logic [dsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsa_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import dsa_pkg::*;

   localparam int SW          = $clog2(NUM_STATES);
   localparam int SB          = SYMBOL_BITS;
   localparam int NUM_SYMBOLS = 1 << SYMBOL_BITS;
   localparam int TDEPTH      = NUM_STATES * NUM_SYMBOLS;
   localparam int TAW         = SW + SB;
   localparam int ADEPTH      = 1 << SW;
   localparam int XW          = (SW > STATE_W) ? SW : STATE_W;

   // Control and run state.
   fsm_type             fsm_ff, fsm_in;
   logic [TAW-1:0]      clear_cnt_ff, clear_cnt_in;
   logic [STATE_W-1:0]  run_state_ff, run_state_in;
   status_type          error_ff, error_in;
   logic [STATE_W-1:0]  initial_state_ff, initial_state_in;
   logic                initial_defined_ff, initial_defined_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Held item fields and response payload.
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic                last_ff, last_in;
   logic [STATE_W-1:0]  rsp_state_ff, rsp_state_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_done_ff, rsp_done_in;

   // Memory ports.
   logic                trans_we;
   logic [TAW-1:0]      trans_waddr;
   logic [TRANS_W-1:0]  trans_wdata;
   logic [TRANS_W-1:0]  trans_rd;
   logic                acc_we;
   logic [SW-1:0]       acc_waddr;
   logic                acc_wdata;
   logic                acc_rd;
   logic                alpha_we;
   logic [SB-1:0]       alpha_waddr;
   logic                alpha_wdata;
   logic                alpha_rd;

   // Index views of the state and symbol fields.
   logic [XW-1:0]       run_ext;
   logic [XW-1:0]       sidx_ext;
   logic [SW-1:0]       run_idx;
   logic [SW-1:0]       sidx_idx;
   logic [SB-1:0]       req_sym_idx;
   logic                req_sym_ok;
   logic                held_sym_ok;
   logic                sidx_ok;
   logic                nxt_ok;
   logic                init_ok;

   assign run_ext     = XW'(run_state_ff);
   assign sidx_ext    = XW'(req_if.state_index);
   assign run_idx     = run_ext[SW-1:0];
   assign sidx_idx    = sidx_ext[SW-1:0];
   assign req_sym_idx = req_if.symbol[SB-1:0];
   assign req_sym_ok  = {1'b0, req_if.symbol} < (SYMBOL_W + 1)'(NUM_SYMBOLS);
   assign held_sym_ok = {1'b0, sym_ff} < (SYMBOL_W + 1)'(NUM_SYMBOLS);
   assign sidx_ok     = 32'(req_if.state_index) < 32'(NUM_STATES);
   assign nxt_ok      = 32'(req_if.next_state) < 32'(NUM_STATES);
   assign init_ok     = 32'(initial_state_ff) < 32'(NUM_STATES);

   dsa_ram #(.WIDTH(TRANS_W), .DEPTH(TDEPTH)) u_trans_ram (
      .clock   (clock),
      .wr_en   (trans_we),
      .wr_addr (trans_waddr),
      .wr_data (trans_wdata),
      .rd_addr ({run_idx, req_sym_idx}),
      .rd_data (trans_rd)
   );

   dsa_ram #(.WIDTH(1), .DEPTH(ADEPTH)) u_accept_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_addr (run_idx),
      .rd_data (acc_rd)
   );

   dsa_ram #(.WIDTH(1), .DEPTH(NUM_SYMBOLS)) u_alpha_ram (
      .clock   (clock),
      .wr_en   (alpha_we),
      .wr_addr (alpha_waddr),
      .wr_data (alpha_wdata),
      .rd_addr (req_sym_idx),
      .rd_data (alpha_rd)
   );

   // Configuration registers.
   always_comb begin
      initial_state_in   = initial_state_ff;
      initial_defined_in = initial_defined_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_INITIAL_STATE:   initial_state_in   = csr_wr_data[STATE_W-1:0];
            CSR_INITIAL_DEFINED: initial_defined_in = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state, memory writes and response.
   always_comb begin
      fsm_in        = fsm_ff;
      clear_cnt_in  = clear_cnt_ff;
      run_state_in  = run_state_ff;
      error_in      = error_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      req_if.ready  = 1'b0;
      trans_we      = 1'b0;
      trans_waddr   = {sidx_idx, req_sym_idx};
      trans_wdata   = '0;
      acc_we        = 1'b0;
      acc_waddr     = sidx_idx;
      acc_wdata     = req_if.flag_value;
      alpha_we      = 1'b0;
      alpha_waddr   = req_sym_idx;
      alpha_wdata   = req_if.flag_value;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (fsm_ff)
         FSM_CLEAR: begin
            trans_we     = 1'b1;
            trans_waddr  = clear_cnt_ff;
            acc_we       = 1'b1;
            acc_waddr    = clear_cnt_ff[SW-1:0];
            acc_wdata    = 1'b0;
            alpha_we     = 1'b1;
            alpha_waddr  = clear_cnt_ff[SB-1:0];
            alpha_wdata  = 1'b0;
            clear_cnt_in = clear_cnt_ff + TAW'(1);
            if (clear_cnt_ff == TAW'(TDEPTH - 1)) begin
               fsm_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               unique case (req_kind_type'(req_if.req_type))
                  REQ_LOAD_TRANS: begin
                     trans_we = sidx_ok && req_sym_ok;
                     if (req_if.flag_value && nxt_ok) begin
                        trans_wdata = {1'b1, req_if.next_state};
                     end
                  end
                  REQ_LOAD_ACCEPT: acc_we   = sidx_ok;
                  REQ_LOAD_ALPHA:  alpha_we = req_sym_ok;
                  REQ_START: begin
                     if (initial_defined_ff && init_ok) begin
                        run_state_in = initial_state_ff;
                        error_in     = STS_RUNNING;
                     end else begin
                        run_state_in = '0;
                        error_in     = STS_NO_INIT;
                     end
                     last_in = req_if.last;
                     fsm_in  = req_if.last ? FSM_FLAG : FSM_EMIT;
                  end
                  REQ_SYMBOL: begin
                     sym_in  = req_if.symbol;
                     last_in = req_if.last;
                     fsm_in  = FSM_STEP;
                  end
                  default: ;
               endcase
            end
         end
         FSM_STEP: begin
            // Table and alphabet data for the held symbol arrive in this cycle.
            if (error_ff == STS_RUNNING) begin
               if (!held_sym_ok || !alpha_rd) begin
                  error_in = STS_BAD_SYM;
               end else if (!trans_rd[TRANS_EXISTS]) begin
                  error_in = STS_NO_TRANS;
               end else begin
                  run_state_in = trans_rd[STATE_W-1:0];
               end
            end
            fsm_in = last_ff ? FSM_FLAG : FSM_EMIT;
         end
         FSM_FLAG: begin
            fsm_in = FSM_EMIT;
         end
         FSM_EMIT: begin
            // The accepting flag read keeps tracking run_state, so waiting here is safe.
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = run_state_ff;
               rsp_done_in  = last_ff;
               if (error_ff != STS_RUNNING) begin
                  rsp_status_in = error_ff;
               end else if (last_ff) begin
                  rsp_status_in = acc_rd ? STS_ACCEPTED : STS_REJECTED;
               end else begin
                  rsp_status_in = STS_RUNNING;
               end
               fsm_in = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff             <= FSM_CLEAR;
         clear_cnt_ff       <= '0;
         run_state_ff       <= '0;
         error_ff           <= STS_RUNNING;
         initial_state_ff   <= '0;
         initial_defined_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         fsm_ff             <= fsm_in;
         clear_cnt_ff       <= clear_cnt_in;
         run_state_ff       <= run_state_in;
         error_ff           <= error_in;
         initial_state_ff   <= initial_state_in;
         initial_defined_ff <= initial_defined_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.current_state = rsp_state_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.done_res      = rsp_done_ff;

endmodule

@@ hdl/dsa_checker.sv @@
// Port-level checks of the string acceptor and the bind that attaches them.
module dsa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [dsa_pkg::REQ_TYPE_W-1:0]  req_type,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [dsa_pkg::STATE_W-1:0]     current_state,
   input logic [dsa_pkg::STATUS_W-1:0]    status,
   input logic                            done_res
);
   import dsa_pkg::*;

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(current_state) && $stable(status) && $stable(done_res))
      else $error("response payload changed while stalled");

   // The table sweep keeps the request side closed right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request accepted during the table sweep");

   // An accepted start or symbol beat closes the request side right after it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
         (req_type == REQ_START || req_type == REQ_SYMBOL) |=> !req_ready)
      else $error("string item did not occupy the block");

   // Only the final beat of a string carries an accept or reject verdict.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_res |-> status != STS_ACCEPTED && status != STS_REJECTED)
      else $error("verdict reported on a non-final beat");

endmodule

bind dfa_string_acceptor_core dsa_checker u_dsa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_type      (req_if.req_type),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .current_state (rsp_if.current_state),
   .status        (rsp_if.status),
   .done_res      (rsp_if.done_res)
);

@@ tb/sv/dfa_string_acceptor_trace_check.sv @@
`timescale 1ns / 100ps
// Trace checker of the string acceptor: mirrors the automaton and compares every response beat.
module dfa_string_acceptor_trace_check (
   input  logic                           clock,
   input  logic                           reset,
   dsa_req_if                             req_mon,
   dsa_rsp_if                             rsp_mon,
   input  logic                           csr_wr_en,
   input  logic [dsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsa_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                             error_count,
   output int                             pending_count
);
   import dsa_pkg::*;

   localparam int NUM_STATES  = 64;
   localparam int NUM_SYMBOLS = 256;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      status_type         status;
      logic               done;
   } trace_entry_type;

   // Each entry holds the exists flag above the target state.
   logic [TRANS_W-1:0] next_table [NUM_STATES][NUM_SYMBOLS];
   logic               accepting [NUM_STATES];
   logic               in_alphabet [NUM_SYMBOLS];
   logic [STATE_W-1:0] walk_state;
   // STS_RUNNING stands for "no error latched".
   status_type         latched_error;
   logic [STATE_W-1:0] start_state;
   logic               start_defined;
   trace_entry_type    trace_q [$];
   int                 errors;

   always @(posedge clock) begin
      trace_entry_type got;
      trace_entry_type want;
      if (reset) begin
         foreach (next_table[s, c]) next_table[s][c] = '0;
         foreach (accepting[s]) accepting[s] = 1'b0;
         foreach (in_alphabet[c]) in_alphabet[c] = 1'b0;
         walk_state    = '0;
         latched_error = STS_RUNNING;
         start_state   = '0;
         start_defined = 1'b0;
         trace_q.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_INITIAL_STATE) begin
               start_state = csr_wr_data[STATE_W-1:0];
            end else begin
               start_defined = csr_wr_data[0];
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.state  = rsp_mon.current_state;
            got.status = status_type'(rsp_mon.status);
            got.done   = rsp_mon.done_res;
            if (trace_q.size() == 0) begin
               $display("%0t: response beat with nothing expected: state %0d status %0d done %0d",
                        $time, got.state, got.status, got.done);
               errors++;
            end else begin
               want = trace_q.pop_front();
               if (got.state != want.state || got.status != want.status
                   || got.done != want.done) begin
                  $display({"%0t: trace mismatch: expected state %0d status %0d done %0d,",
                            " got state %0d status %0d done %0d"}, $time, want.state,
                           want.status, want.done, got.state, got.status, got.done);
                  errors++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.req_type)
               REQ_LOAD_TRANS: begin
                  next_table[req_mon.state_index][req_mon.symbol] =
                     req_mon.flag_value ? {1'b1, req_mon.next_state} : '0;
               end
               REQ_LOAD_ACCEPT: begin
                  accepting[req_mon.state_index] = req_mon.flag_value;
               end
               REQ_LOAD_ALPHA: begin
                  in_alphabet[req_mon.symbol] = req_mon.flag_value;
               end
               REQ_START: begin
                  if (start_defined) begin
                     walk_state    = start_state;
                     latched_error = STS_RUNNING;
                  end else begin
                     walk_state    = '0;
                     latched_error = STS_NO_INIT;
                  end
               end
               REQ_SYMBOL: begin
                  // Once an error is latched the walk is frozen until the next start.
                  if (latched_error == STS_RUNNING) begin
                     if (!in_alphabet[req_mon.symbol]) begin
                        latched_error = STS_BAD_SYM;
                     end else if (next_table[walk_state][req_mon.symbol][TRANS_EXISTS]) begin
                        walk_state = next_table[walk_state][req_mon.symbol][STATE_W-1:0];
                     end else begin
                        latched_error = STS_NO_TRANS;
                     end
                  end
               end
               default: ;
            endcase

            if (req_mon.req_type == REQ_START || req_mon.req_type == REQ_SYMBOL) begin
               want.state = walk_state;
               want.done  = req_mon.last;
               if (latched_error != STS_RUNNING) begin
                  want.status = latched_error;
               end else if (!req_mon.last) begin
                  want.status = STS_RUNNING;
               end else begin
                  want.status = accepting[walk_state] ? STS_ACCEPTED : STS_REJECTED;
               end
               trace_q.push_back(want);
            end
         end
      end
      error_count   <= errors;
      pending_count <= trace_q.size();
   end

endmodule

@@ tb/sv/dfa_string_acceptor_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top of the string acceptor: clock, reset, stimulus, response stalls and the verdict.
module dfa_string_acceptor_core_tb;
   import dsa_pkg::*;

   localparam int ITEM_TARGET  = 1550;
   localparam int PHASE_ITEMS  = 260;
   localparam int NUM_PICKS    = 8;
   localparam int NUM_BYTES    = 5;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT_BEAT = 300;
   // This leaves a wide margin over the table sweep after reset and a slow run of all items.
   localparam int CYCLE_LIMIT  = 300000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    error_count;
   int                    pending_count;
   int                    items_sent = 0;
   int                    cycle_count = 0;
   int                    rsp_beats = 0;
   bit                    hold_done = 1'b0;

   dsa_req_if req_if ();
   dsa_rsp_if rsp_if ();

   dfa_string_acceptor_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   dfa_string_acceptor_trace_check trace_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("dfa_string_acceptor_core_tb: done, errors");
         $finish;
      end
   end

   // Response side: random stalls, one long hold-off and a stretch with no stalls.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) rsp_beats++;
         if (!hold_done && rsp_beats == HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= (rsp_beats >= 600 && rsp_beats < 800) || $urandom_range(99) >= 20;
      end
   end

   task automatic send_req(input int unsigned kind, input int unsigned sidx,
                           input int unsigned sym, input int unsigned nxt,
                           input int unsigned flag, input int unsigned fin);
      if (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(99) < 20) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= REQ_TYPE_W'(kind);
      req_if.state_index <= STATE_W'(sidx);
      req_if.symbol      <= SYMBOL_W'(sym);
      req_if.next_state  <= STATE_W'(nxt);
      req_if.flag_value  <= flag[0];
      req_if.last        <= fin[0];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (kind <= REQ_SYMBOL) items_sent++;
   endtask

   // Stops offering and waits until every expected beat has arrived and the block is quiet.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input int unsigned init_state, input int unsigned defined);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_INITIAL_STATE;
      csr_wr_data <= CSR_DATA_W'(init_state);
      @(posedge clock);
      csr_index   <= CSR_INITIAL_DEFINED;
      csr_wr_data <= CSR_DATA_W'(defined);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [STATE_W-1:0]  picks [NUM_PICKS];
      logic [SYMBOL_W-1:0] bytes [NUM_BYTES];
      logic [STATE_W-1:0]  first_state;
      int                  phase;
      int                  phase_end;
      int                  len;
      bit                  broken;

      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_INITIAL_STATE;
      csr_wr_data        <= '0;
      req_if.valid       <= 1'b0;
      req_if.req_type    <= REQ_LOAD_TRANS;
      req_if.state_index <= '0;
      req_if.symbol      <= '0;
      req_if.next_state  <= '0;
      req_if.flag_value  <= 1'b0;
      req_if.last        <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Symbols before any start walk from state 0, and nothing is in the alphabet yet.
      send_req(REQ_SYMBOL, 0, 8'h00, 0, 0, 0);
      send_req(REQ_SYMBOL, 63, 8'hff, 63, 1, 1);
      // No initial state is configured out of reset.
      send_req(REQ_START, 0, 0, 0, 0, 1);
      for (int k = 1; k <= 3; k++) begin
         send_req(REQ_SYMBOL + k, $urandom_range(63), $urandom_range(255),
                  $urandom_range(63), $urandom_range(1), $urandom_range(1));
      end
      wait_drained();
      write_config(63, 1);

      send_req(REQ_LOAD_ALPHA, 0, 8'hff, 0, 1, 0);
      send_req(REQ_LOAD_ALPHA, 0, 8'h00, 0, 1, 0);
      send_req(REQ_LOAD_ALPHA, 0, 8'h5a, 0, 1, 0);
      send_req(REQ_LOAD_ALPHA, 0, 8'h5a, 0, 0, 0);
      send_req(REQ_LOAD_TRANS, 63, 8'hff, 0, 1, 0);
      send_req(REQ_LOAD_TRANS, 0, 8'h00, 63, 1, 0);
      send_req(REQ_LOAD_TRANS, 0, 8'hff, 42, 1, 0);
      send_req(REQ_LOAD_TRANS, 0, 8'hff, 42, 0, 0);
      send_req(REQ_LOAD_ACCEPT, 63, 0, 0, 1, 0);
      send_req(REQ_LOAD_ACCEPT, 0, 0, 0, 0, 0);
      send_req(REQ_START, 0, 0, 0, 0, 0);
      send_req(REQ_SYMBOL, 0, 8'hff, 0, 0, 0);
      send_req(REQ_SYMBOL, 0, 8'h00, 0, 0, 1);
      // A string of length zero gets its verdict on the start beat.
      send_req(REQ_START, 0, 0, 0, 0, 1);
      // The transition out of state 0 on 0xff was removed, so the walk latches an error.
      send_req(REQ_START, 0, 0, 0, 0, 0);
      send_req(REQ_SYMBOL, 0, 8'hff, 0, 0, 0);
      send_req(REQ_SYMBOL, 0, 8'hff, 0, 0, 0);
      send_req(REQ_SYMBOL, 0, 8'h00, 0, 0, 0);
      send_req(REQ_SYMBOL, 0, 8'h00, 0, 0, 1);
      // 0x5a left the alphabet again; a new start clears the latched error first.
      send_req(REQ_START, 0, 0, 0, 0, 0);
      send_req(REQ_SYMBOL, 0, 8'h5a, 0, 0, 1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         case (phase % 5)
            0:       first_state = '0;
            2:       first_state = '1;
            default: first_state = STATE_W'($urandom_range(63));
         endcase
         write_config(first_state, phase % 5 != 1);

         // A small automaton over a few states and bytes, so that most strings walk deep.
         picks[0] = first_state;
         for (int i = 1; i < NUM_PICKS; i++) picks[i] = STATE_W'($urandom_range(63));
         for (int j = 0; j < NUM_BYTES; j++) begin
            bytes[j] = SYMBOL_W'($urandom_range(255));
            send_req(REQ_LOAD_ALPHA, $urandom_range(63), bytes[j], $urandom_range(63), 1,
                     $urandom_range(1));
         end
         for (int i = 0; i < NUM_PICKS; i++) begin
            send_req(REQ_LOAD_ACCEPT, picks[i], $urandom_range(255), $urandom_range(63),
                     $urandom_range(1), $urandom_range(1));
            for (int j = 0; j < NUM_BYTES; j++) begin
               send_req(REQ_LOAD_TRANS, picks[i], bytes[j],
                        picks[$urandom_range(NUM_PICKS - 1)], $urandom_range(99) >= 8,
                        $urandom_range(1));
            end
         end

         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 10) begin
               send_req($urandom_range(7), $urandom_range(63), $urandom_range(255),
                        $urandom_range(63), $urandom_range(1), $urandom_range(1));
            end
            len    = ($urandom_range(99) < 5) ? $urandom_range(20) : $urandom_range(6);
            broken = $urandom_range(99) < 5;
            send_req(REQ_START, $urandom_range(63), $urandom_range(255), $urandom_range(63),
                     $urandom_range(1), len == 0 && !broken);
            for (int k = 1; k <= len; k++) begin
               send_req(REQ_SYMBOL, $urandom_range(63),
                        ($urandom_range(99) < 92) ? bytes[$urandom_range(NUM_BYTES - 1)]
                                                  : $urandom_range(255),
                        $urandom_range(63), $urandom_range(1), k == len && !broken);
            end
         end
         phase++;
      end

      wait_drained();
      if (error_count == 0) begin
         $display("dfa_string_acceptor_core_tb: done, clean");
      end else begin
         $display("dfa_string_acceptor_core_tb: done, errors");
      end
      $finish;
   end

endmodule
